>>> src/slin_pkg.sv
// Shared types, constants and the key translation table for the scancode line input.
// No dependencies; imported by every module of the block.
package slin_pkg;

  localparam int ScW          = 8;
  localparam int CodeW        = 7;
  localparam int CharW        = 7;
  localparam int PosW         = 8;
  localparam int CapW         = 9;
  localparam int NumCodes     = 84;
  localparam int NumKeys      = 128;
  localparam int LineDepthDef = 256;

  localparam logic [CodeW-1:0] EnterCode     = 7'h1C;
  localparam logic [CharW-1:0] BackspaceChar = 7'h08;
  localparam logic [CapW-1:0]  CapReset      = 9'd256;

  // Register addresses (word index)
  localparam logic RegLineCap = 1'b0;

  typedef enum logic [1:0] {
    EvStore = 2'd0,
    EvErase = 2'd1,
    EvEnter = 2'd2
  } event_kind_e;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             released;
    logic             known;     // translates to a non-zero character
    logic [CharW-1:0] ch;
  } key_info_t;

  typedef struct packed {
    event_kind_e      kind;
    logic [CharW-1:0] ch;
    logic [PosW-1:0]  pos;
    logic             done;
  } line_res_t;

  localparam logic [CharW-1:0] KeyTable [NumCodes] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h2d, 7'h3d,
    7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6f, 7'h70,
    7'h5b, 7'h5d,
    7'h0a, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60,
    7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f,
    7'h00, 7'h2a,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00,
    7'h00, 7'h37, 7'h38, 7'h39, 7'h2d, 7'h34, 7'h35, 7'h36, 7'h2b, 7'h31, 7'h32, 7'h33,
    7'h30, 7'h2e
  };

  function automatic logic [CharW-1:0] key_lookup(input logic [CodeW-1:0] code);
    logic [CharW-1:0] ch;
    ch = '0;
    if (code < CodeW'(NumCodes)) begin
      ch = KeyTable[code];
    end
    return ch;
  endfunction

endpackage

>>> src/scancode_line_input_core.sv
// Scancode line input: stream in raw set-1 scancodes, stream out line edit events.
// Path: an accepted scancode request goes into the input register, then its result into the
// result register. Throughput: one scancode per cycle while the event stream is not stalled;
// held marks and line index update in one pass.
// Reset: held marks and line index cleared, line capacity set to 256; no clearing pass.
// Depends on slin_pkg, slin_decode and slin_line_ctrl.
module scancode_line_input_core
  import slin_pkg::*;
#(
  parameter int LINE_DEPTH = LineDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // scancode stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] scancode
  // event stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [6:0] key_char, [14:7] position, [15] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
  output logic        m_axis_tlast    // line_done
);

  logic [CapW-1:0] cap_q;
  logic            in_valid_q;
  logic [ScW-1:0]  sc_q;
  logic            take;
  key_info_t       info;
  line_res_t       res;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (psel && penable && pwrite && (paddr[2] == RegLineCap)) begin
      cap_q <= pwdata[CapW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegLineCap) ? {{(32-CapW){1'b0}}, cap_q} : '0;

  // Input register
  assign s_axis_tready = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sc_q <= s_axis_tdata;
    end
  end

  slin_decode u_decode (
    .scancode_i (sc_q),
    .info_o     (info)
  );

  slin_line_ctrl #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_line_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_q),
    .info_i      (info),
    .line_cap_i  (cap_q),
    .take_o      (take),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {1'b0, res.pos, res.ch};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.done;

endmodule

>>> src/slin_decode.sv
// Scancode decode: splits off the release bit and translates the key code.
// Depends on slin_pkg.
module slin_decode
  import slin_pkg::*;
(
  input  logic [ScW-1:0] scancode_i,
  output key_info_t      info_o
);

  logic [CharW-1:0] ch;

  assign ch = key_lookup(scancode_i[CodeW-1:0]);

  always_comb begin
    info_o.code     = scancode_i[CodeW-1:0];
    info_o.released = scancode_i[ScW-1];
    info_o.known    = (ch != '0);
    info_o.ch       = ch;
  end

endmodule

>>> src/slin_line_ctrl.sv
// Line state (held marks, line index) and the result register.
// Depends on slin_pkg; fed by slin_decode from the input register.
module slin_line_ctrl
  import slin_pkg::*;
#(
  parameter int LINE_DEPTH = LineDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  key_info_t       info_i,
  input  logic [CapW-1:0] line_cap_i,
  output logic            take_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output line_res_t       res_o
);

  localparam int IdxW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CmpW = (IdxW + 1 > 13) ? IdxW + 1 : 13;

  logic [NumKeys-1:0] held_q, held_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               res_valid_q;
  line_res_t          res_q, res_d;
  logic               has_res;
  logic               fire;

  logic [CmpW-1:0] cap_ext, cap_eff, idx_ext, idx_inc, idx_dec;

  assign take_o = !res_valid_q || res_ready_i;
  assign fire   = req_valid_i && take_o;

  // Capacity clamped to 1 .. LINE_DEPTH
  assign cap_ext = CmpW'(line_cap_i);
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_ext > CmpW'(LINE_DEPTH)) begin
      cap_eff = CmpW'(LINE_DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign idx_ext = CmpW'(idx_q);
  assign idx_inc = idx_ext + CmpW'(1);
  assign idx_dec = idx_ext - CmpW'(1);

  always_comb begin
    held_d  = held_q;
    idx_d   = idx_q;
    has_res = 1'b0;
    res_d   = res_q;
    if (fire && info_i.known) begin
      if (info_i.released) begin
        held_d[info_i.code] = 1'b0;
      end else if (!held_q[info_i.code]) begin
        held_d[info_i.code] = 1'b1;
        res_d.ch = info_i.ch;
        if (info_i.code == EnterCode) begin
          has_res    = 1'b1;
          res_d.kind = EvEnter;
          res_d.pos  = idx_ext[PosW-1:0];
          res_d.done = 1'b1;
          idx_d      = '0;
        end else if (info_i.ch == BackspaceChar) begin
          // erase on an empty line only sets the held mark
          if (idx_q != '0) begin
            has_res    = 1'b1;
            res_d.kind = EvErase;
            res_d.pos  = idx_dec[PosW-1:0];
            res_d.done = 1'b0;
            idx_d      = idx_dec[IdxW-1:0];
          end
        end else begin
          has_res    = 1'b1;
          res_d.kind = EvStore;
          res_d.pos  = idx_ext[PosW-1:0];
          res_d.done = (idx_inc >= cap_eff);
          idx_d      = res_d.done ? '0 : idx_inc[IdxW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      held_q <= held_d;
      idx_q  <= idx_d;
      if (fire && has_res) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_res) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
